### src/sbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blitter package
// Shared sizes, operation and status codes for the clipped sprite blitter.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int SCREEN_WIDTH    = 320;
   localparam int SCREEN_HEIGHT   = 240;
   localparam int SPRITE_SIDE_MAX = 64;
   localparam int SPRITE_COUNT    = 64;

   localparam int SPR_WORDS = SPRITE_SIDE_MAX * SPRITE_SIDE_MAX;
   localparam int SCR_WORDS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ID_W      = $clog2(SPRITE_COUNT);
   localparam int SIDE_W    = $clog2(SPRITE_SIDE_MAX + 1);
   localparam int SPR_PIX_W = $clog2(SPR_WORDS);
   localparam int SPR_ADR_W = ID_W + SPR_PIX_W;
   localparam int SCR_ADR_W = $clog2(SCR_WORDS);
   localparam int CLR_W     = (SPR_ADR_W > SCR_ADR_W) ? SPR_ADR_W : SCR_ADR_W;

   localparam logic [2:0] OP_WRITE     = 3'd0;
   localparam logic [2:0] OP_READ      = 3'd1;
   localparam logic [2:0] OP_FILL      = 3'd2;
   localparam logic [2:0] OP_PAINT     = 3'd3;
   localparam logic [2:0] OP_PAINT_ALL = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BADID = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

endpackage
`default_nettype wire

### src/sprite_blitter_with_clipping_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped sprite blitter
// One screen and a set of sprites held in on-chip memories, with word
// access, fill, clipped paint and paint-all commands.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes the pixel and header memories, one word of
// each a cycle over max(SPRITE_COUNT*SPRITE_SIDE_MAX^2, SCREEN_WIDTH*SCREEN_HEIGHT)
// addresses (262144 at the default sizes); no command is taken until it ends.
// A fill writes one pixel per cycle. A paint reads the two headers and then
// walks every source pixel through the source memory's single read port, in
// the steps S_PPIX and S_PWRITE per pixel after S_PROW and S_PWAIT per row;
// paint all repeats that for every sprite. One command is worked on at a time,
// and one result is returned for each command.
module sprite_blitter_with_clipping_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // tdata from bit 0: operation[2:0], first_id[9:3], second_id[16:10],
   // word_index[33:17], write_value[65:34], red[73:66], green[81:74],
   // blue[89:82], alpha[97:90], zero fill to 104 bits.
   input  wire logic [103:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata from bit 0: status[1:0], read_data[33:2], zero fill to 40 bits.
   output      logic [39:0] rsp_tdata
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WORD, S_WDONE, S_FILL, S_PHDR, S_PSETUP, S_PROW, S_PPIX,
      S_PWAIT, S_PWRITE, S_RESP
   } state_type;

   localparam int PW = sbc_pkg::SPR_PIX_W;

   logic [31:0] spr_pix_mem [sbc_pkg::SPRITE_COUNT * sbc_pkg::SPR_WORDS];
   logic [31:0] scr_pix_mem [sbc_pkg::SCR_WORDS];
   logic [31:0] hdr_x_mem [sbc_pkg::SPRITE_COUNT];
   logic [31:0] hdr_y_mem [sbc_pkg::SPRITE_COUNT];
   logic [sbc_pkg::SIDE_W-1:0] hdr_w_mem [sbc_pkg::SPRITE_COUNT];
   logic [sbc_pkg::SIDE_W-1:0] hdr_h_mem [sbc_pkg::SPRITE_COUNT];

   state_type state_ff;
   logic [sbc_pkg::CLR_W:0] clr_ff;
   logic [2:0]  op_ff;
   logic [6:0]  a_ff, b_ff;
   logic [16:0] idx_ff;
   logic [31:0] val_ff;
   logic [1:0]  status_ff;
   logic [31:0] data_ff;
   logic        all_ff;
   logic [sbc_pkg::ID_W:0] all_id_ff;
   // Paint walk.
   logic signed [32:0] sx_ff, sy_ff;
   logic [10:0] sw_ff, sh_ff, dw_ff, dh_ff;
   logic [10:0] px_ff, py_ff;
   logic signed [33:0] ty_ff;
   logic        row_ok_ff;
   logic [sbc_pkg::SCR_ADR_W-1:0] srow_ff;
   logic [sbc_pkg::SCR_ADR_W-1:0] drow_ff;
   logic [31:0] fill_ff;
   logic [sbc_pkg::CLR_W-1:0] cnt_ff, n_ff;
   logic        hit_ff;
   logic [sbc_pkg::CLR_W-1:0] wadr_ff;
   logic [31:0] rd_spr_ff, rd_scr_ff;
   logic [31:0] hx_a_ff, hy_a_ff;
   logic [sbc_pkg::SIDE_W-1:0] hw_a_ff, hh_a_ff, hw_b_ff, hh_b_ff;

   // Memory ports.
   logic        spr_we, scr_we;
   logic [sbc_pkg::SPR_ADR_W-1:0] spr_wa, spr_ra;
   logic [sbc_pkg::SCR_ADR_W-1:0] scr_wa, scr_ra;
   logic [31:0] spr_wd, scr_wd;
   logic        hx_we, hy_we, hw_we, hh_we;
   logic [sbc_pkg::ID_W-1:0] hdr_wa, hdr_ra, hdr_rb;
   logic [31:0] hx_wd, hy_wd;
   logic [sbc_pkg::SIDE_W-1:0] hw_wd, hh_wd;

   always_ff @(posedge clock) begin
      if (spr_we) spr_pix_mem[spr_wa] <= spr_wd;
      rd_spr_ff <= spr_pix_mem[spr_ra];
      if (scr_we) scr_pix_mem[scr_wa] <= scr_wd;
      rd_scr_ff <= scr_pix_mem[scr_ra];
   end

   always_ff @(posedge clock) begin
      if (hx_we) hdr_x_mem[hdr_wa] <= hx_wd;
      if (hy_we) hdr_y_mem[hdr_wa] <= hy_wd;
      if (hw_we) hdr_w_mem[hdr_wa] <= hw_wd;
      if (hh_we) hdr_h_mem[hdr_wa] <= hh_wd;
      hx_a_ff <= hdr_x_mem[hdr_ra];
      hy_a_ff <= hdr_y_mem[hdr_ra];
      hw_a_ff <= hdr_w_mem[hdr_ra];
      hh_a_ff <= hdr_h_mem[hdr_ra];
      hw_b_ff <= hdr_w_mem[hdr_rb];
      hh_b_ff <= hdr_h_mem[hdr_rb];
   end

   logic [6:0]  in_a, in_b;
   logic        a_ok, b_ok, a_scr, b_scr;
   logic [sbc_pkg::ID_W-1:0] a_id;
   logic [16:0] pidx;
   logic        in_range;
   logic [31:0] cval;

   assign in_a  = req_tdata[9:3];
   assign in_b  = req_tdata[16:10];
   assign a_scr = (a_ff == 7'h7f);
   assign b_scr = (b_ff == 7'h7f);
   assign a_ok  = a_scr || (!a_ff[6] && {25'd0, a_ff} < 32'(sbc_pkg::SPRITE_COUNT));
   assign b_ok  = b_scr || (!b_ff[6] && {25'd0, b_ff} < 32'(sbc_pkg::SPRITE_COUNT));
   assign a_id  = a_ff[sbc_pkg::ID_W-1:0];
   assign pidx  = idx_ff - 17'd4;
   assign in_range = a_scr ? ({15'd0, pidx} < 32'(sbc_pkg::SCR_WORDS))
                           : ({15'd0, pidx} < 32'(sbc_pkg::SPR_WORDS));
   assign cval  = (val_ff > 32'(sbc_pkg::SPRITE_SIDE_MAX)) ?
                  32'(sbc_pkg::SPRITE_SIDE_MAX) : val_ff;

   // Paint source and destination selection.
   logic [6:0] ps, pd;
   logic [sbc_pkg::ID_W-1:0] ps_id, pd_id;
   assign ps    = all_ff ? {{(7-sbc_pkg::ID_W){1'b0}}, all_id_ff[sbc_pkg::ID_W-1:0]} : a_ff;
   assign pd    = all_ff ? 7'h7f : b_ff;
   assign ps_id = ps[sbc_pkg::ID_W-1:0];
   assign pd_id = pd[sbc_pkg::ID_W-1:0];

   logic signed [33:0] tx;
   assign tx = 34'(sx_ff) + 34'($signed({1'b0, px_ff}));

   always_comb begin
      hdr_ra = (state_ff == S_IDLE) ? in_a[sbc_pkg::ID_W-1:0] : ps_id;
      hdr_rb = pd_id;
      hx_we = 1'b0; hy_we = 1'b0; hw_we = 1'b0; hh_we = 1'b0;
      hdr_wa = a_id;
      hx_wd = val_ff; hy_wd = val_ff;
      hw_wd = sbc_pkg::SIDE_W'(cval); hh_wd = sbc_pkg::SIDE_W'(cval);
      if (state_ff == S_CLEAR) begin
         hx_we = 1'b1; hy_we = 1'b1; hw_we = 1'b1; hh_we = 1'b1;
         hdr_wa = clr_ff[sbc_pkg::ID_W-1:0];
         hx_wd = '0; hy_wd = '0; hw_wd = '0; hh_wd = '0;
      end else if (state_ff == S_WORD && op_ff == sbc_pkg::OP_WRITE && a_ok && !a_scr
                   && idx_ff < 17'd4) begin
         hx_we = (idx_ff[1:0] == 2'd0);
         hy_we = (idx_ff[1:0] == 2'd1);
         hw_we = (idx_ff[1:0] == 2'd2);
         hh_we = (idx_ff[1:0] == 2'd3);
      end
   end

   always_comb begin
      spr_we = 1'b0; scr_we = 1'b0;
      spr_wa = '0; scr_wa = '0; spr_wd = '0; scr_wd = '0;
      spr_ra = '0; scr_ra = '0;
      unique case (state_ff)
         S_CLEAR: begin
            spr_we = 1'b1; scr_we = {1'b0, clr_ff[sbc_pkg::CLR_W-1:0]} <
                     (sbc_pkg::CLR_W+1)'(sbc_pkg::SCR_WORDS);
            spr_wa = clr_ff[sbc_pkg::SPR_ADR_W-1:0];
            scr_wa = clr_ff[sbc_pkg::SCR_ADR_W-1:0];
         end
         S_WORD: begin
            spr_ra = {a_id, pidx[PW-1:0]};
            scr_ra = pidx[sbc_pkg::SCR_ADR_W-1:0];
            if (op_ff == sbc_pkg::OP_WRITE && a_ok && idx_ff >= 17'd4 && in_range) begin
               spr_we = !a_scr; scr_we = a_scr;
               spr_wa = {a_id, pidx[PW-1:0]};
               scr_wa = pidx[sbc_pkg::SCR_ADR_W-1:0];
               spr_wd = val_ff; scr_wd = val_ff;
            end
         end
         S_FILL: begin
            spr_we = !a_scr; scr_we = a_scr;
            spr_wa = {a_id, cnt_ff[PW-1:0]};
            scr_wa = cnt_ff[sbc_pkg::SCR_ADR_W-1:0];
            spr_wd = fill_ff; scr_wd = fill_ff;
         end
         S_PPIX: begin
            spr_ra = {ps_id, PW'(srow_ff + sbc_pkg::SCR_ADR_W'(px_ff))};
            scr_ra = srow_ff + sbc_pkg::SCR_ADR_W'(px_ff);
         end
         S_PWRITE: begin
            if (hit_ff) begin
               spr_we = (pd != 7'h7f); scr_we = (pd == 7'h7f);
               spr_wa = {pd_id, wadr_ff[PW-1:0]};
               scr_wa = wadr_ff[sbc_pkg::SCR_ADR_W-1:0];
               spr_wd = (ps == 7'h7f) ? rd_scr_ff : rd_spr_ff;
               scr_wd = spr_wd;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         req_tready <= 1'b0;
         rsp_tvalid <= 1'b0;
         all_ff     <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (sbc_pkg::CLR_W+1)'(sbc_pkg::SPRITE_COUNT * sbc_pkg::SPR_WORDS
                     > sbc_pkg::SCR_WORDS ? sbc_pkg::SPRITE_COUNT * sbc_pkg::SPR_WORDS - 1
                     : sbc_pkg::SCR_WORDS - 1)) begin
                  state_ff <= S_IDLE; req_tready <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  req_tready <= 1'b0;
                  op_ff  <= req_tdata[2:0];
                  a_ff   <= in_a; b_ff <= in_b;
                  idx_ff <= req_tdata[33:17];
                  val_ff <= req_tdata[65:34];
                  fill_ff <= {req_tdata[73:66], req_tdata[81:74], req_tdata[89:82],
                              req_tdata[97:90]};
                  status_ff <= sbc_pkg::ST_OK; data_ff <= '0;
                  all_ff <= 1'b0; all_id_ff <= '0; cnt_ff <= '0;
                  state_ff <= S_WORD;
               end
            end
            S_WORD: begin
               state_ff <= S_RESP;
               unique case (op_ff)
                  sbc_pkg::OP_WRITE, sbc_pkg::OP_READ: begin
                     if (!a_ok) status_ff <= sbc_pkg::ST_BADID;
                     else if (idx_ff < 17'd4) begin
                        if (op_ff == sbc_pkg::OP_READ) begin
                           case (idx_ff[1:0])
                              2'd0: data_ff <= a_scr ? 32'd0 : hx_a_ff;
                              2'd1: data_ff <= a_scr ? 32'd0 : hy_a_ff;
                              2'd2: data_ff <= a_scr ? 32'(sbc_pkg::SCREEN_WIDTH)
                                              : 32'(hw_a_ff);
                              default: data_ff <= a_scr ? 32'(sbc_pkg::SCREEN_HEIGHT)
                                              : 32'(hh_a_ff);
                           endcase
                        end
                     end else if (!in_range) status_ff <= sbc_pkg::ST_RANGE;
                     else if (op_ff == sbc_pkg::OP_READ) state_ff <= S_WDONE;
                  end
                  sbc_pkg::OP_FILL: begin
                     if (!a_ok) status_ff <= sbc_pkg::ST_BADID;
                     else begin
                        n_ff <= a_scr ? sbc_pkg::CLR_W'(sbc_pkg::SCR_WORDS)
                                : sbc_pkg::CLR_W'(32'(hw_a_ff) * 32'(hh_a_ff));
                        if (a_scr || (hw_a_ff != '0 && hh_a_ff != '0))
                           state_ff <= S_FILL;
                     end
                  end
                  sbc_pkg::OP_PAINT: begin
                     if (!a_ok || !b_ok || a_ff == b_ff) status_ff <= sbc_pkg::ST_BADID;
                     else state_ff <= S_PHDR;
                  end
                  sbc_pkg::OP_PAINT_ALL: begin
                     all_ff <= 1'b1; state_ff <= S_PHDR;
                  end
                  default: ;
               endcase
            end
            S_WDONE: begin
               data_ff  <= a_scr ? rd_scr_ff : rd_spr_ff;
               state_ff <= S_RESP;
            end
            S_FILL: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff + 1'b1 == n_ff) state_ff <= S_RESP;
            end
            S_PHDR: begin
               state_ff <= S_PSETUP;
            end
            S_PSETUP: begin
               sx_ff <= (ps == 7'h7f) ? 33'sd0 : $signed({hx_a_ff[31], hx_a_ff});
               sy_ff <= (ps == 7'h7f) ? 33'sd0 : $signed({hy_a_ff[31], hy_a_ff});
               sw_ff <= (ps == 7'h7f) ? 11'(sbc_pkg::SCREEN_WIDTH) : 11'(hw_a_ff);
               sh_ff <= (ps == 7'h7f) ? 11'(sbc_pkg::SCREEN_HEIGHT) : 11'(hh_a_ff);
               dw_ff <= (pd == 7'h7f) ? 11'(sbc_pkg::SCREEN_WIDTH) : 11'(hw_b_ff);
               dh_ff <= (pd == 7'h7f) ? 11'(sbc_pkg::SCREEN_HEIGHT) : 11'(hh_b_ff);
               py_ff <= '0; srow_ff <= '0;
               state_ff <= S_PROW;
            end
            S_PROW: begin
               if (py_ff >= sh_ff || sw_ff == '0 || dw_ff == '0 || dh_ff == '0) begin
                  if (all_ff && all_id_ff != (sbc_pkg::ID_W+1)'(sbc_pkg::SPRITE_COUNT - 1)) begin
                     all_id_ff <= all_id_ff + 1'b1; state_ff <= S_PHDR;
                  end else state_ff <= S_RESP;
               end else begin
                  ty_ff <= 34'(sy_ff) + 34'($signed({1'b0, py_ff}));
                  row_ok_ff <= 1'b0;
                  px_ff <= '0;
                  state_ff <= S_PWAIT;
               end
            end
            S_PWAIT: begin
               row_ok_ff <= (ty_ff >= 0) && (ty_ff < 34'($signed({1'b0, dh_ff})));
               drow_ff <= sbc_pkg::SCR_ADR_W'(ty_ff[16:0] * 17'(dw_ff));
               state_ff <= S_PPIX;
            end
            S_PPIX: begin
               hit_ff <= row_ok_ff && (tx >= 0) && (tx < 34'($signed({1'b0, dw_ff})));
               wadr_ff <= sbc_pkg::CLR_W'(drow_ff + sbc_pkg::SCR_ADR_W'(tx[16:0]));
               state_ff <= S_PWRITE;
            end
            S_PWRITE: begin
               if (px_ff + 1'b1 == sw_ff) begin
                  py_ff <= py_ff + 1'b1;
                  srow_ff <= srow_ff + sbc_pkg::SCR_ADR_W'(sw_ff);
                  state_ff <= S_PROW;
               end else begin
                  px_ff <= px_ff + 1'b1;
                  state_ff <= S_PPIX;
               end
            end
            S_RESP: begin
               if (!rsp_tvalid) rsp_tvalid <= 1'b1;
               else if (rsp_tready) begin
                  rsp_tvalid <= 1'b0; req_tready <= 1'b1; state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tdata = {6'd0, data_ff, status_ff};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept while result pending");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> status_ff != 2'd3) else $error("bad status");
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff != sbc_pkg::ST_OK |-> data_ff == '0)
      else $error("data on failed command");

endmodule
`default_nettype wire
